FILE: design/c3f_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package c3f_pkg;

  localparam int OUT_BITS       = 20;
  localparam int M_DATA_BITS    = ((OUT_BITS + 7) / 8) * 8;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;
  localparam int DIM_BITS       = 11;
  localparam int MIN_DIM        = 3;
  localparam int FIFO_DEPTH     = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_TOP    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_MIDDLE = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_BOTTOM = 3'd4;

  localparam logic [DIM_BITS-1:0]      IMAGE_WIDTH_RESET   = 11'd640;
  localparam logic [DIM_BITS-1:0]      IMAGE_HEIGHT_RESET  = 11'd480;
  localparam logic [CFG_DATA_BITS-1:0] KERNEL_TOP_RESET    = 24'd0;
  localparam logic [CFG_DATA_BITS-1:0] KERNEL_MIDDLE_RESET = 24'd256;
  localparam logic [CFG_DATA_BITS-1:0] KERNEL_BOTTOM_RESET = 24'd0;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

endpackage
`default_nettype wire

FILE: design/c3f_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module c3f_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire             clk,
  input  wire             wr_en,
  input  wire [AW-1:0]    wr_addr,
  input  wire [WIDTH-1:0] wr_data,
  input  wire [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: design/c3f_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module c3f_cell #(
  parameter int PIXEL_BITS = 8,
  parameter int COEF_BITS  = 8,
  localparam int PROD_W = PIXEL_BITS + COEF_BITS + 1,
  localparam int SUM_W  = PROD_W + 2
) (
  input  wire                      clk,
  input  wire                      shift,
  input  wire [3*PIXEL_BITS-1:0]   col_in,    // top, middle, bottom pixel
  input  wire [3*COEF_BITS-1:0]    coefs,     // top, middle, bottom coefficient
  output logic [3*PIXEL_BITS-1:0]  col_out,   // top, middle, bottom pixel
  output logic signed [SUM_W-1:0]  col_sum
);

  logic [3*PIXEL_BITS-1:0]  col;
  logic signed [PROD_W-1:0] prod [3];

  always_ff @(posedge clk) begin
    if (shift) begin
      col <= col_in;
    end
    for (int i = 0; i < 3; i++) begin
      prod[i] <= $signed({1'b0, col[i*PIXEL_BITS +: PIXEL_BITS]}) *
                 $signed(coefs[i*COEF_BITS +: COEF_BITS]);
    end
    col_sum <= SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]);
  end

  assign col_out = col;

endmodule
`default_nettype wire

FILE: design/c3f_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module c3f_fifo #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 8,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire c3f_pkg::fifo_ctrl_t ctrl,
  input  wire [WIDTH-1:0]          push_data,
  output logic [WIDTH-1:0]         pop_data,
  output logic                     not_empty
);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entries[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctrl.push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (ctrl.pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(ctrl.push) - (PW+1)'(ctrl.pop);
    end
  end

  assign pop_data  = entries[rd_ptr];
  assign not_empty = (count != '0);

endmodule
`default_nettype wire

FILE: design/conv3x3_image_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// 3x3 convolution over a raster pixel stream. Pixels enter on s_* in raster order, s_tuser
// marking the first pixel of a frame; each interior position gives one signed 20-bit sum of
// nine pixel-coefficient products on m_*, with m_tlast on the last result of a row and
// m_tuser on the last result of a frame. The border is not padded, so a W x H frame yields
// (W-2) x (H-2) results. The block takes one pixel per clock while s_tready is high: each
// line store is a RAM with one write and one read per cycle, and the window is a row of
// three column cells that shift once per pixel. Results pass the s1, column, product and
// sum registers into the eight-entry output queue, which lets input continue while results
// wait; with m_tready held low, input stops once eight results are outstanding.
// Write width, height and kernel rows on cfg_* only while no frame is in flight; width and
// height are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT. No clearing pass after reset.
module conv3x3_image_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 8,
  parameter int COEF_BITS  = 8,
  localparam int S_DATA_W  = ((PIXEL_BITS + 7) / 8) * 8
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire [S_DATA_W-1:0]                  s_tdata,   // pixel
  input  wire                                 s_tuser,   // frame_start
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [c3f_pkg::M_DATA_BITS-1:0]     m_tdata,   // filtered
  output logic                                m_tlast,   // row_end
  output logic                                m_tuser,   // frame_end
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [c3f_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire [c3f_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int KW     = (3 * COEF_BITS > c3f_pkg::CFG_DATA_BITS) ?
                          3 * COEF_BITS : c3f_pkg::CFG_DATA_BITS;
  localparam int SUM_W  = PIXEL_BITS + COEF_BITS + 3;
  localparam int TOT_W  = SUM_W + 2;
  localparam int ACC_W  = (TOT_W > c3f_pkg::OUT_BITS) ? TOT_W : c3f_pkg::OUT_BITS;
  localparam int ENT_W  = c3f_pkg::OUT_BITS + 2;
  localparam int UW     = $clog2(c3f_pkg::FIFO_DEPTH) + 1;

  logic [c3f_pkg::DIM_BITS-1:0]      image_width;
  logic [c3f_pkg::DIM_BITS-1:0]      image_height;
  logic [c3f_pkg::CFG_DATA_BITS-1:0] kernel_top;
  logic [c3f_pkg::CFG_DATA_BITS-1:0] kernel_middle;
  logic [c3f_pkg::CFG_DATA_BITS-1:0] kernel_bottom;
  logic [KW-1:0]                     kern_ext [3];
  logic [3*COEF_BITS-1:0]            cell_coef [3];

  logic [CW-1:0] col_pos;
  logic [RW-1:0] row_pos;
  logic [CW-1:0] c0;
  logic [RW-1:0] r0;
  logic [CW-1:0] col_last;
  logic [RW-1:0] row_last;
  logic          last_col;
  logic          last_row;
  logic          at_interior;
  logic          accept;
  logic          pop;
  logic [UW-1:0] used;

  logic                  s1_valid;
  logic                  s1_res;
  logic                  s1_row_end;
  logic                  s1_frame_end;
  logic [CW-1:0]         s1_idx;
  logic [PIXEL_BITS-1:0] s1_px;
  logic                  s1_hit;
  logic [PIXEL_BITS-1:0] s1_fwd_up;
  logic [PIXEL_BITS-1:0] s1_fwd_lo;
  logic [PIXEL_BITS-1:0] up_rd;
  logic [PIXEL_BITS-1:0] lo_rd;
  logic [PIXEL_BITS-1:0] up_eff;
  logic [PIXEL_BITS-1:0] lo_eff;

  logic       s2_valid;
  logic       s3_valid;
  logic       s4_valid;
  logic [1:0] s2_flags;
  logic [1:0] s3_flags;
  logic [1:0] s4_flags;

  logic [3*PIXEL_BITS-1:0]  col_new;
  logic [3*PIXEL_BITS-1:0]  col_mid;
  logic [3*PIXEL_BITS-1:0]  col_old;
  logic signed [SUM_W-1:0]  csum [3];
  logic signed [ACC_W-1:0]  total;

  c3f_pkg::fifo_ctrl_t fifo_ctrl;
  logic [ENT_W-1:0]    push_data;
  logic [ENT_W-1:0]    pop_data;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= c3f_pkg::IMAGE_WIDTH_RESET;
      image_height  <= c3f_pkg::IMAGE_HEIGHT_RESET;
      kernel_top    <= c3f_pkg::KERNEL_TOP_RESET;
      kernel_middle <= c3f_pkg::KERNEL_MIDDLE_RESET;
      kernel_bottom <= c3f_pkg::KERNEL_BOTTOM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        c3f_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data[c3f_pkg::DIM_BITS-1:0];
        c3f_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data[c3f_pkg::DIM_BITS-1:0];
        c3f_pkg::REG_KERNEL_TOP:    kernel_top    <= cfg_data;
        c3f_pkg::REG_KERNEL_MIDDLE: kernel_middle <= cfg_data;
        c3f_pkg::REG_KERNEL_BOTTOM: kernel_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  assign kern_ext[0] = KW'(kernel_top);
  assign kern_ext[1] = KW'(kernel_middle);
  assign kern_ext[2] = KW'(kernel_bottom);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        cell_coef[k][i*COEF_BITS +: COEF_BITS] = kern_ext[i][k*COEF_BITS +: COEF_BITS];
      end
    end
  end

  // Position tracking
  always_comb begin
    if (image_width < c3f_pkg::DIM_BITS'(c3f_pkg::MIN_DIM)) begin
      col_last = CW'(c3f_pkg::MIN_DIM - 1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      col_last = CW'(MAX_WIDTH - 1);
    end else begin
      col_last = CW'(image_width - 1'b1);
    end
    if (image_height < c3f_pkg::DIM_BITS'(c3f_pkg::MIN_DIM)) begin
      row_last = RW'(c3f_pkg::MIN_DIM - 1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      row_last = RW'(MAX_HEIGHT - 1);
    end else begin
      row_last = RW'(image_height - 1'b1);
    end
  end

  assign c0          = s_tuser ? '0 : col_pos;
  assign r0          = s_tuser ? '0 : row_pos;
  assign last_col    = (c0 >= col_last);
  assign last_row    = (r0 >= row_last);
  assign at_interior = (c0 >= CW'(2)) && (r0 >= RW'(2));

  assign s_tready = (used != UW'(c3f_pkg::FIFO_DEPTH));
  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
      used    <= '0;
    end else begin
      if (accept) begin
        if (last_col) begin
          col_pos <= '0;
          row_pos <= last_row ? '0 : r0 + 1'b1;
        end else begin
          col_pos <= c0 + 1'b1;
          row_pos <= r0;
        end
      end
      used <= used + UW'(accept && at_interior) - UW'(pop);
    end
  end

  // Line stores; forward the previous write when it hits the same column
  c3f_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_upper (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_idx),
    .wr_data (lo_eff),
    .rd_addr (c0),
    .rd_data (up_rd)
  );

  c3f_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_lower (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_idx),
    .wr_data (s1_px),
    .rd_addr (c0),
    .rd_data (lo_rd)
  );

  assign up_eff = s1_hit ? s1_fwd_up : up_rd;
  assign lo_eff = s1_hit ? s1_fwd_lo : lo_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_res       <= at_interior;
    s1_row_end   <= last_col;
    s1_frame_end <= last_col && last_row;
    s1_idx       <= c0;
    s1_px        <= s_tdata[PIXEL_BITS-1:0];
    s1_hit       <= s1_valid && (s1_idx == c0);
    s1_fwd_up    <= lo_eff;
    s1_fwd_lo    <= s1_px;
  end

  // Window: three column cells, newest on the right
  assign col_new = {s1_px, lo_eff, up_eff};

  c3f_cell #(.PIXEL_BITS(PIXEL_BITS), .COEF_BITS(COEF_BITS)) u_cell2 (
    .clk     (clk),
    .shift   (s1_valid),
    .col_in  (col_new),
    .coefs   (cell_coef[2]),
    .col_out (col_mid),
    .col_sum (csum[2])
  );

  c3f_cell #(.PIXEL_BITS(PIXEL_BITS), .COEF_BITS(COEF_BITS)) u_cell1 (
    .clk     (clk),
    .shift   (s1_valid),
    .col_in  (col_mid),
    .coefs   (cell_coef[1]),
    .col_out (col_old),
    .col_sum (csum[1])
  );

  c3f_cell #(.PIXEL_BITS(PIXEL_BITS), .COEF_BITS(COEF_BITS)) u_cell0 (
    .clk     (clk),
    .shift   (s1_valid),
    .col_in  (col_old),
    .coefs   (cell_coef[0]),
    .col_out (),
    .col_sum (csum[0])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_res;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
    s2_flags <= {s1_frame_end, s1_row_end};
    s3_flags <= s2_flags;
    s4_flags <= s3_flags;
  end

  assign total = ACC_W'(csum[0]) + ACC_W'(csum[1]) + ACC_W'(csum[2]);

  // Output queue
  assign fifo_ctrl.push = s4_valid;
  assign fifo_ctrl.pop  = pop;
  assign push_data      = {s4_flags, total[c3f_pkg::OUT_BITS-1:0]};

  c3f_fifo #(.WIDTH(ENT_W), .DEPTH(c3f_pkg::FIFO_DEPTH)) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (fifo_ctrl),
    .push_data (push_data),
    .pop_data  (pop_data),
    .not_empty (m_tvalid)
  );

  assign m_tdata = c3f_pkg::M_DATA_BITS'(pop_data[c3f_pkg::OUT_BITS-1:0]);
  assign m_tlast = pop_data[c3f_pkg::OUT_BITS];
  assign m_tuser = pop_data[c3f_pkg::OUT_BITS+1];

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(c3f_pkg::FIFO_DEPTH))
    else $error("outstanding result count exceeds output queue depth");

  a_valid_has_credit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> used != '0)
    else $error("result offered with no outstanding transfer counted");

  a_forward_same_col: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_hit |-> $past(s1_valid) && ($past(s1_idx) == s1_idx))
    else $error("line store forward without a matching write");

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("frame end without row end");

endmodule
`default_nettype wire

FILE: dv/tb_conv3x3_image_filter.sv
`timescale 1ns / 1ps
module tb_conv3x3_image_filter;

  localparam int MAX_DIM       = 1024;
  localparam int COEF_W        = 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_PIXELS = 1250;
  localparam int SETTLE_CYCLES = 12;
  localparam int TALL_ROWS     = 40;

  typedef struct {
    logic [c3f_pkg::OUT_BITS-1:0] filtered;
    bit                           row_end;
    bit                           frame_end;
  } conv_result_t;

  logic                               clk;
  logic                               rst;
  logic                               s_tvalid;
  logic                               s_tready;
  logic [7:0]                         s_tdata;
  logic                               s_tuser;
  logic                               m_tvalid;
  logic                               m_tready;
  logic [c3f_pkg::M_DATA_BITS-1:0]    m_tdata;
  logic                               m_tlast;
  logic                               m_tuser;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [c3f_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [c3f_pkg::CFG_DATA_BITS-1:0]  cfg_data;

  logic [c3f_pkg::DIM_BITS-1:0]      width_reg;
  logic [c3f_pkg::DIM_BITS-1:0]      height_reg;
  logic [c3f_pkg::CFG_DATA_BITS-1:0] kernel_rows [3];
  logic [7:0]                        upper_line [MAX_DIM];
  logic [7:0]                        lower_line [MAX_DIM];
  logic [7:0]                        window [9];
  int                                col_pos;
  int                                row_pos;

  conv_result_t pending_sums [$];
  conv_result_t next_sum;
  int           errors;
  int           pixels_sent;
  int           quiet_cycles = 0;
  int           sink_hold = 0;
  bit           src_gaps;
  bit           sink_stalls;

  conv3x3_image_filter u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int clamp_dim(input logic [c3f_pkg::DIM_BITS-1:0] v);
    if (v < c3f_pkg::MIN_DIM) return c3f_pkg::MIN_DIM;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic void predict_pixel(input logic [7:0] px, input bit fs);
    int                 w;
    int                 h;
    int                 sum;
    int                 cf;
    int                 pv;
    logic [7:0]         up;
    logic [7:0]         lo;
    logic signed [7:0]  coef;
    bit                 last_col;
    bit                 last_row;
    conv_result_t       res;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    up = upper_line[col_pos];
    lo = lower_line[col_pos];
    upper_line[col_pos] = lo;
    lower_line[col_pos] = px;
    for (int i = 0; i < 3; i++) begin
      window[i*3]   = window[i*3+1];
      window[i*3+1] = window[i*3+2];
    end
    window[2] = up;
    window[5] = lo;
    window[8] = px;
    last_col = col_pos >= w - 1;
    last_row = row_pos >= h - 1;
    if (col_pos >= 2 && row_pos >= 2) begin
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          coef = kernel_rows[i][k*COEF_W +: COEF_W];
          cf   = coef;
          pv   = window[i*3+k];
          sum += pv * cf;
        end
      end
      res.filtered  = sum[c3f_pkg::OUT_BITS-1:0];
      res.row_end   = last_col;
      res.frame_end = last_col && last_row;
      pending_sums.insert(pending_sums.size(), res);
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endfunction

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [c3f_pkg::CFG_DATA_BITS-1:0] pick_dim();
    logic [c3f_pkg::CFG_DATA_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0: v = c3f_pkg::CFG_DATA_BITS'($urandom_range(0, 2));
      1: v = c3f_pkg::CFG_DATA_BITS'($urandom_range(9, 24));
      default: v = c3f_pkg::CFG_DATA_BITS'($urandom_range(3, 8));
    endcase
    if ($urandom_range(0, 3) == 0)
      v[c3f_pkg::CFG_DATA_BITS-1:c3f_pkg::DIM_BITS] =
        (c3f_pkg::CFG_DATA_BITS - c3f_pkg::DIM_BITS)'($urandom);
    return v;
  endfunction

  function automatic logic [c3f_pkg::CFG_DATA_BITS-1:0] pick_kernel_row();
    logic [c3f_pkg::CFG_DATA_BITS-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 24'h808080;
      1: v = 24'h7F7F7F;
      2: v = 24'h000000;
      3: begin
        for (int k = 0; k < 3; k++) begin
          case ($urandom_range(0, 4))
            0: v[k*COEF_W +: COEF_W] = 8'h80;
            1: v[k*COEF_W +: COEF_W] = 8'h7F;
            2: v[k*COEF_W +: COEF_W] = 8'h00;
            3: v[k*COEF_W +: COEF_W] = 8'h01;
            default: v[k*COEF_W +: COEF_W] = 8'hFF;
          endcase
        end
      end
      default: v = c3f_pkg::CFG_DATA_BITS'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_pixel(input logic [7:0] px, input bit fs);
    int gap;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = px;
    s_tuser  = fs;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_pixel(px, fs);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int w, input int h, input bit with_start, input int fill);
    for (int n = 0; n < w * h; n++)
      send_pixel(fill < 0 ? pick_pixel() : 8'(fill), with_start && n == 0);
  endtask

  task automatic write_reg(input logic [c3f_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [c3f_pkg::CFG_DATA_BITS-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      c3f_pkg::REG_IMAGE_WIDTH:   width_reg      = val[c3f_pkg::DIM_BITS-1:0];
      c3f_pkg::REG_IMAGE_HEIGHT:  height_reg     = val[c3f_pkg::DIM_BITS-1:0];
      c3f_pkg::REG_KERNEL_TOP:    kernel_rows[0] = val;
      c3f_pkg::REG_KERNEL_MIDDLE: kernel_rows[1] = val;
      c3f_pkg::REG_KERNEL_BOTTOM: kernel_rows[2] = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // reset kernel passes the centre pixel through; dimensions below 3 clamp up
  task automatic test_identity_kernel();
    write_reg(c3f_pkg::REG_IMAGE_WIDTH, 24'd0);
    write_reg(c3f_pkg::REG_IMAGE_HEIGHT, 24'd2);
    send_frame(3, 3, 1'b1, -1);
    wait_drained();
  endtask

  task automatic test_extreme_sums_and_restart();
    write_reg(c3f_pkg::REG_IMAGE_WIDTH, 24'd3);
    write_reg(c3f_pkg::REG_IMAGE_HEIGHT, 24'd3);
    write_reg(c3f_pkg::REG_KERNEL_TOP, 24'h808080);
    write_reg(c3f_pkg::REG_KERNEL_MIDDLE, 24'h808080);
    write_reg(c3f_pkg::REG_KERNEL_BOTTOM, 24'h808080);
    // drop a partial frame by restarting on frame_start
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'hFF, 1'b0);
    send_frame(3, 3, 1'b1, 255);
    wait_drained();
    write_reg(c3f_pkg::REG_KERNEL_TOP, 24'h7F7F7F);
    write_reg(c3f_pkg::REG_KERNEL_MIDDLE, 24'h7F7F7F);
    write_reg(c3f_pkg::REG_KERNEL_BOTTOM, 24'h7F7F7F);
    send_frame(3, 3, 1'b1, 255);
    wait_drained();
  endtask

  // oversized height clamps to the maximum, so no frame end in the first rows
  task automatic test_max_geometry();
    write_reg(c3f_pkg::REG_IMAGE_WIDTH, 24'd3);
    write_reg(c3f_pkg::REG_IMAGE_HEIGHT, 24'h0007FF);
    write_reg(c3f_pkg::REG_KERNEL_TOP, pick_kernel_row());
    write_reg(c3f_pkg::REG_KERNEL_MIDDLE, pick_kernel_row());
    write_reg(c3f_pkg::REG_KERNEL_BOTTOM, pick_kernel_row());
    for (int n = 0; n < 3 * TALL_ROWS; n++)
      send_pixel(pick_pixel(), n == 0);
    wait_drained();
    write_reg(c3f_pkg::REG_IMAGE_HEIGHT, 24'd3);
    send_frame(3, 3, 1'b1, -1);
    wait_drained();
  endtask

  task automatic test_random_frames();
    int start;
    int w;
    int h;
    int frames;
    int partial;
    bit first;
    start = pixels_sent;
    first = 1'b1;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      if (pixels_sent - start >= RANDOM_PIXELS * 3 / 4) begin
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
      end
      if (first || $urandom_range(0, 3) != 0)
        write_reg(c3f_pkg::REG_IMAGE_WIDTH, pick_dim());
      if (first || $urandom_range(0, 3) != 0)
        write_reg(c3f_pkg::REG_IMAGE_HEIGHT, pick_dim());
      if (first || $urandom_range(0, 2) != 0)
        write_reg(c3f_pkg::REG_KERNEL_TOP, pick_kernel_row());
      if (first || $urandom_range(0, 2) != 0)
        write_reg(c3f_pkg::REG_KERNEL_MIDDLE, pick_kernel_row());
      if (first || $urandom_range(0, 2) != 0)
        write_reg(c3f_pkg::REG_KERNEL_BOTTOM, pick_kernel_row());
      if ($urandom_range(0, 9) == 0)
        write_reg(c3f_pkg::CFG_INDEX_BITS'($urandom_range(5, 7)),
                  c3f_pkg::CFG_DATA_BITS'($urandom));
      first = 1'b0;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      frames = $urandom_range(1, 4);
      for (int f = 0; f < frames; f++) begin
        if ($urandom_range(0, 7) == 0) begin
          partial = $urandom_range(1, w * h - 1);
          for (int n = 0; n < partial; n++)
            send_pixel(pick_pixel(), n == 0 && $urandom_range(0, 1) == 0);
          send_frame(w, h, 1'b1, -1);
        end else begin
          send_frame(w, h, $urandom_range(0, 3) != 0, -1);
        end
      end
      wait_drained();
    end
  endtask

  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      m_tready = 1'b0;
    end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
      sink_hold = $urandom_range(0, 2);
      m_tready  = 1'b0;
    end else begin
      m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_sums.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, got filtered %0d row_end %0b frame_end %0b",
                 $time, $signed(m_tdata[c3f_pkg::OUT_BITS-1:0]), m_tlast, m_tuser);
      end else begin
        next_sum = pending_sums.pop_front();
        if (m_tdata !== c3f_pkg::M_DATA_BITS'(next_sum.filtered)) begin
          errors++;
          $display("%0t: filtered expected %0d (0x%h) got %0d (0x%h)", $time,
                   $signed(next_sum.filtered), c3f_pkg::M_DATA_BITS'(next_sum.filtered),
                   $signed(m_tdata[c3f_pkg::OUT_BITS-1:0]), m_tdata);
        end
        if (m_tlast !== next_sum.row_end) begin
          errors++;
          $display("%0t: row_end expected %0b got %0b", $time, next_sum.row_end, m_tlast);
        end
        if (m_tuser !== next_sum.frame_end) begin
          errors++;
          $display("%0t: frame_end expected %0b got %0b", $time, next_sum.frame_end, m_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_conv3x3_image_filter: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = 8'h00;
    s_tuser     = 1'b0;
    m_tready    = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = c3f_pkg::REG_IMAGE_WIDTH;
    cfg_data    = '0;
    errors      = 0;
    pixels_sent = 0;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    width_reg      = c3f_pkg::IMAGE_WIDTH_RESET;
    height_reg     = c3f_pkg::IMAGE_HEIGHT_RESET;
    kernel_rows[0] = c3f_pkg::KERNEL_TOP_RESET;
    kernel_rows[1] = c3f_pkg::KERNEL_MIDDLE_RESET;
    kernel_rows[2] = c3f_pkg::KERNEL_BOTTOM_RESET;
    for (int i = 0; i < MAX_DIM; i++) begin
      upper_line[i] = 8'h00;
      lower_line[i] = 8'h00;
    end
    for (int i = 0; i < 9; i++) window[i] = 8'h00;
    col_pos = 0;
    row_pos = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_identity_kernel();
    test_extreme_sums_and_restart();
    test_max_geometry();
    test_random_frames();

    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    wait_drained();
    if (errors == 0) begin
      $display("tb_conv3x3_image_filter: PASS");
    end else begin
      $display("tb_conv3x3_image_filter: FAIL");
    end
    $finish;
  end

endmodule
